FILE: rtl/rci_pkg.sv
// shared types, constants and helpers for the ray/circle intersection core
package rci_pkg;

  // field widths
  localparam int unsigned COORD_W = 20;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned RADIUS_W = 19;
  localparam int unsigned T_W     = 22;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  // internal widths
  localparam int unsigned W_W   = COORD_W + 1;   // origin - center
  localparam int unsigned L2_W  = 32;            // dir_x^2 + dir_y^2
  localparam int unsigned FRAC_SH = 28;          // length scaling
  localparam int unsigned MAG_W = (L2_W + FRAC_SH) / 2;
  localparam int unsigned NUM_W = DIR_W + FRAC_SH;
  localparam int unsigned QUO_W = 15;
  localparam int unsigned P_W   = 24;
  localparam int unsigned DISC_W = 48;
  localparam int unsigned S_W   = DISC_W / 2;

  // saturation bounds of the distance outputs
  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  // sideband carried through the length square root
  typedef struct packed {
    logic             zero;
    logic             sx;
    logic             sy;
    logic [DIR_W-1:0] adx;
    logic [DIR_W-1:0] ady;
    logic [W_W-1:0]   wx;
    logic [W_W-1:0]   wy;
  } sq1_side_t;

  // sideband carried through the normalizing divider
  typedef struct packed {
    logic           zero;
    logic           sx;
    logic           sy;
    logic [W_W-1:0] wx;
    logic [W_W-1:0] wy;
  } div_side_t;

  // sideband carried through the discriminant square root
  typedef struct packed {
    logic           miss;
    logic [P_W-1:0] p;
  } sq2_side_t;

  // clamp a distance into the output range
  function automatic logic signed [T_W-1:0] sat_t(input logic signed [P_W+1:0] v);
    logic signed [T_W-1:0] r;
    if (v > (P_W+2)'(T_MAX)) begin
      r = T_MAX;
    end else if (v < (P_W+2)'(T_MIN)) begin
      r = T_MIN;
    end else begin
      r = v[T_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/ray_circle_intersect_core.sv
// Ray/circle intersection core: one 2D ray per cycle against a configured circle.
// Fully pipelined: a new ray is accepted every cycle. Each ray passes through one
// input stage, a 30-stage square root for the direction length, a 15-stage
// divider that normalizes the direction, five multiply/add stages, a 24-stage
// square root of the discriminant and the output register. The whole pipeline
// holds while a result waits downstream, so in_stall_o follows out_stall_i
// whenever out_valid_o is high. The circle registers are written through the
// cfg port by the user while no ray is in flight; the core does not enforce this.
module ray_circle_intersect_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rci_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rci_pkg::COORD_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rci_pkg::COORD_W-1:0]    origin_x_i,
  input  logic signed [rci_pkg::COORD_W-1:0]    origin_y_i,
  input  logic signed [rci_pkg::DIR_W-1:0]      dir_x_i,
  input  logic signed [rci_pkg::DIR_W-1:0]      dir_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  output logic signed [rci_pkg::T_W-1:0]        t_near_o,
  output logic signed [rci_pkg::T_W-1:0]        t_far_o
);
  import rci_pkg::*;

  logic en;

  // circle registers
  logic signed [COORD_W-1:0]  cx_q, cy_q;
  logic        [RADIUS_W-1:0] r_q;

  // pipeline advances unless a result is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      r_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTER_X: cx_q <= cfg_data_i;
        CFG_CENTER_Y: cy_q <= cfg_data_i;
        CFG_RADIUS:   r_q  <= cfg_data_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a: squared length, magnitudes, offset from center
  logic signed [L2_W-1:0] dxx, dyy;
  logic        [L2_W-1:0] a_l2_q;
  logic                   a_vld_q;
  sq1_side_t              a_side_q, a_side_d;

  assign dxx = dir_x_i * dir_x_i;
  assign dyy = dir_y_i * dir_y_i;

  always_comb begin
    a_side_d.zero = (dir_x_i == '0) && (dir_y_i == '0);
    a_side_d.sx   = dir_x_i[DIR_W-1];
    a_side_d.sy   = dir_y_i[DIR_W-1];
    a_side_d.adx  = dir_x_i[DIR_W-1] ? DIR_W'(-dir_x_i) : dir_x_i;
    a_side_d.ady  = dir_y_i[DIR_W-1] ? DIR_W'(-dir_y_i) : dir_y_i;
    a_side_d.wx   = W_W'(origin_x_i) - W_W'(cx_q);
    a_side_d.wy   = W_W'(origin_y_i) - W_W'(cy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_l2_q   <= unsigned'(dxx) + unsigned'(dyy);
      a_side_q <= a_side_d;
    end
  end

  // direction length
  logic                     m_vld;
  logic [MAG_W-1:0]         m_mag;
  logic [$bits(sq1_side_t)-1:0] m_side_raw;
  sq1_side_t                m_side;

  rci_sqrt #(
    .IN_W   (L2_W + FRAC_SH),
    .SIDE_W ($bits(sq1_side_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_vld_q),
    .rad_i   ({a_l2_q, {FRAC_SH{1'b0}}}),
    .side_i  (a_side_q),
    .valid_o (m_vld),
    .root_o  (m_mag),
    .side_o  (m_side_raw)
  );

  assign m_side = m_side_raw;

  // normalize the direction
  logic                         n_vld;
  logic [QUO_W-1:0]             n_qx, n_qy;
  logic [$bits(div_side_t)-1:0] n_side_raw;
  div_side_t                    n_side, m_div_side;

  always_comb begin
    m_div_side.zero = m_side.zero;
    m_div_side.sx   = m_side.sx;
    m_div_side.sy   = m_side.sy;
    m_div_side.wx   = m_side.wx;
    m_div_side.wy   = m_side.wy;
  end

  rci_div #(
    .N_W    (NUM_W),
    .D_W    (MAG_W),
    .Q_W    (QUO_W),
    .SIDE_W ($bits(div_side_t))
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_vld),
    .num_a_i ({m_side.adx, {FRAC_SH{1'b0}}}),
    .num_b_i ({m_side.ady, {FRAC_SH{1'b0}}}),
    .den_i   (m_mag),
    .side_i  (m_div_side),
    .valid_o (n_vld),
    .quo_a_o (n_qx),
    .quo_b_o (n_qy),
    .side_o  (n_side_raw)
  );

  assign n_side = n_side_raw;

  // stage b: signed unit direction
  logic signed [DIR_W-1:0] b_nx_q, b_ny_q;
  logic signed [W_W-1:0]   b_wx_q, b_wy_q;
  logic                    b_zero_q, b_vld_q;

  // stage c: products
  logic signed [W_W+DIR_W-1:0] c_px_q, c_py_q;
  logic signed [2*W_W-1:0]     c_wxx_q, c_wyy_q;
  logic        [2*RADIUS_W-1:0] c_rr_q;
  logic                        c_zero_q, c_vld_q;

  // stage d: p and q
  logic signed [P_W-1:0]        d_p_q;
  logic signed [2*W_W+1:0]      d_qq_q;
  logic                         d_zero_q, d_vld_q;
  logic signed [W_W+DIR_W:0]    dot_sum;

  // stage e: p squared
  logic signed [DISC_W-1:0]     e_pp_q;
  logic signed [2*W_W+1:0]      e_qq_q;
  logic signed [P_W-1:0]        e_p_q;
  logic                         e_zero_q, e_vld_q;

  // stage f: discriminant
  logic signed [DISC_W-1:0]     f_disc_d, f_disc_q;
  sq2_side_t                    f_side_q;
  logic                         f_vld_q;

  assign dot_sum = (W_W+DIR_W+1)'(c_px_q) + (W_W+DIR_W+1)'(c_py_q)
                 + (W_W+DIR_W+1)'(1 << 13);
  assign f_disc_d = e_pp_q - DISC_W'(e_qq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= n_vld;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // apply the direction signs
      b_nx_q   <= n_side.sx ? -DIR_W'({1'b0, n_qx}) : DIR_W'({1'b0, n_qx});
      b_ny_q   <= n_side.sy ? -DIR_W'({1'b0, n_qy}) : DIR_W'({1'b0, n_qy});
      b_wx_q   <= n_side.wx;
      b_wy_q   <= n_side.wy;
      b_zero_q <= n_side.zero;
      // dot terms and squares
      c_px_q   <= b_wx_q * b_nx_q;
      c_py_q   <= b_wy_q * b_ny_q;
      c_wxx_q  <= b_wx_q * b_wx_q;
      c_wyy_q  <= b_wy_q * b_wy_q;
      c_rr_q   <= r_q * r_q;
      c_zero_q <= b_zero_q;
      // p rounded half up, q exact
      d_p_q    <= P_W'(dot_sum >>> 14);
      d_qq_q   <= (2*W_W+2)'(c_wxx_q) + (2*W_W+2)'(c_wyy_q)
                - (2*W_W+2)'({1'b0, c_rr_q});
      d_zero_q <= c_zero_q;
      // p squared
      e_pp_q   <= d_p_q * d_p_q;
      e_qq_q   <= d_qq_q;
      e_p_q    <= d_p_q;
      e_zero_q <= d_zero_q;
      // discriminant sign or a zero direction decides the miss
      f_disc_q      <= f_disc_d;
      f_side_q.miss <= e_zero_q || f_disc_d[DISC_W-1];
      f_side_q.p    <= e_p_q;
    end
  end

  // discriminant root
  logic                         s_vld;
  logic [S_W-1:0]               s_root;
  logic [$bits(sq2_side_t)-1:0] s_side_raw;
  sq2_side_t                    s_side;

  rci_sqrt #(
    .IN_W   (DISC_W),
    .SIDE_W ($bits(sq2_side_t))
  ) u_disc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld_q),
    .rad_i   (f_disc_q),
    .side_i  (f_side_q),
    .valid_o (s_vld),
    .root_o  (s_root),
    .side_o  (s_side_raw)
  );

  assign s_side = s_side_raw;

  // output stage: distances with saturation
  logic signed [P_W+1:0] tn_raw, tf_raw;
  logic                  out_vld_q, hit_q;
  logic signed [T_W-1:0] tn_q, tf_q;

  assign tn_raw = -(P_W+2)'($signed(s_side.p)) - (P_W+2)'({1'b0, s_root});
  assign tf_raw = -(P_W+2)'($signed(s_side.p)) + (P_W+2)'({1'b0, s_root});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= !s_side.miss;
      tn_q  <= s_side.miss ? '0 : sat_t(tn_raw);
      tf_q  <= s_side.miss ? '0 : sat_t(tf_raw);
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;
  assign t_near_o    = tn_q;
  assign t_far_o     = tf_q;

endmodule

FILE: rtl/rci_sqrt.sv
// pipelined integer square root, one result bit per stage
module rci_sqrt #(
  parameter int unsigned IN_W   = 60,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned REM_W = OUT_W + 3;

  logic [IN_W-1:0]   rad_q  [OUT_W];
  logic [REM_W-1:0]  rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];
  logic [OUT_W-1:0]  vld_q;

  for (genvar i = 0; i < OUT_W; i++) begin : g_stage
    logic [IN_W-1:0]   rad_c;
    logic [REM_W-1:0]  rem_c;
    logic [OUT_W-1:0]  root_c;
    logic [SIDE_W-1:0] side_c;
    logic              vld_c;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // stage input select
    if (i == 0) begin : g_first
      assign rad_c  = rad_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = side_i;
      assign vld_c  = valid_i;
    end else begin : g_next
      assign rad_c  = rad_q[i-1];
      assign rem_c  = rem_q[i-1];
      assign root_c = root_q[i-1];
      assign side_c = side_q[i-1];
      assign vld_c  = vld_q[i-1];
    end

    // bring down two radicand bits, trial subtract
    assign rem_sh = {rem_c[REM_W-3:0], rad_c[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_c, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= rad_c << 2;
        side_q[i] <= side_c;
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_c[OUT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_c[OUT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign side_o  = side_q[OUT_W-1];

endmodule

FILE: rtl/rci_div.sv
// pipelined restoring divider, two numerators over one divisor, one bit per stage
module rci_div #(
  parameter int unsigned N_W    = 44,
  parameter int unsigned D_W    = 30,
  parameter int unsigned Q_W    = 15,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [N_W-1:0]    num_a_i,
  input  logic [N_W-1:0]    num_b_i,
  input  logic [D_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_a_o,
  output logic [Q_W-1:0]    quo_b_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned REM_W = D_W + 1;

  logic [REM_W-1:0]  rem_a_q [Q_W];
  logic [REM_W-1:0]  rem_b_q [Q_W];
  logic [Q_W-1:0]    lo_a_q  [Q_W];
  logic [Q_W-1:0]    lo_b_q  [Q_W];
  logic [Q_W-1:0]    quo_a_q [Q_W];
  logic [Q_W-1:0]    quo_b_q [Q_W];
  logic [D_W-1:0]    den_q   [Q_W];
  logic [SIDE_W-1:0] side_q  [Q_W];
  logic [Q_W-1:0]    vld_q;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_a_c, rem_b_c;
    logic [Q_W-1:0]    lo_a_c, lo_b_c;
    logic [Q_W-1:0]    quo_a_c, quo_b_c;
    logic [D_W-1:0]    den_c;
    logic [SIDE_W-1:0] side_c;
    logic              vld_c;
    logic [REM_W-1:0]  sh_a, sh_b;
    logic [REM_W-1:0]  den_x;

    // stage input select; the top part of the numerator starts as remainder
    if (i == 0) begin : g_first
      assign rem_a_c = REM_W'(num_a_i[N_W-1:Q_W]);
      assign rem_b_c = REM_W'(num_b_i[N_W-1:Q_W]);
      assign lo_a_c  = num_a_i[Q_W-1:0];
      assign lo_b_c  = num_b_i[Q_W-1:0];
      assign quo_a_c = '0;
      assign quo_b_c = '0;
      assign den_c   = den_i;
      assign side_c  = side_i;
      assign vld_c   = valid_i;
    end else begin : g_next
      assign rem_a_c = rem_a_q[i-1];
      assign rem_b_c = rem_b_q[i-1];
      assign lo_a_c  = lo_a_q[i-1];
      assign lo_b_c  = lo_b_q[i-1];
      assign quo_a_c = quo_a_q[i-1];
      assign quo_b_c = quo_b_q[i-1];
      assign den_c   = den_q[i-1];
      assign side_c  = side_q[i-1];
      assign vld_c   = vld_q[i-1];
    end

    // shift in next numerator bit
    assign sh_a  = {rem_a_c[REM_W-2:0], lo_a_c[Q_W-1]};
    assign sh_b  = {rem_b_c[REM_W-2:0], lo_b_c[Q_W-1]};
    assign den_x = {1'b0, den_c};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_a_q[i]  <= lo_a_c << 1;
        lo_b_q[i]  <= lo_b_c << 1;
        den_q[i]   <= den_c;
        side_q[i]  <= side_c;
        if (sh_a >= den_x) begin
          rem_a_q[i] <= sh_a - den_x;
          quo_a_q[i] <= {quo_a_c[Q_W-2:0], 1'b1};
        end else begin
          rem_a_q[i] <= sh_a;
          quo_a_q[i] <= {quo_a_c[Q_W-2:0], 1'b0};
        end
        if (sh_b >= den_x) begin
          rem_b_q[i] <= sh_b - den_x;
          quo_b_q[i] <= {quo_b_c[Q_W-2:0], 1'b1};
        end else begin
          rem_b_q[i] <= sh_b;
          quo_b_q[i] <= {quo_b_c[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_a_o = quo_a_q[Q_W-1];
  assign quo_b_o = quo_b_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

FILE: rtl/rci_checker.sv
// port-level checks for the ray/circle intersection core, bound to the top level
module rci_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               hit_o,
  input logic signed [rci_pkg::T_W-1:0]     t_near_o,
  input logic signed [rci_pkg::T_W-1:0]     t_far_o
);

  // a held result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input only stalls behind a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a miss reports zero distances
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> t_near_o == '0 && t_far_o == '0)
    else $error("miss with nonzero distance");

  // near never exceeds far on a hit
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> t_near_o <= t_far_o)
    else $error("near distance beyond far distance");

endmodule

bind ray_circle_intersect_core rci_checker u_rci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .t_near_o    (t_near_o),
  .t_far_o     (t_far_o)
);
